// ===== sv/adilo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adilo_pkg
// Shared types, constants and helper functions of the alpha disk dilation
// outline block.
// ----------------------------------------------------------------------------
package adilo_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 4;

   // Field widths fixed by the interface.
   localparam int CHAN_BITS   = 8;
   localparam int PIXEL_BITS  = 4 * CHAN_BITS;
   localparam int CFG_W_BITS  = 11;
   localparam int CFG_H_BITS  = 11;
   localparam int CFG_R_BITS  = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values.
   localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd1024;
   localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 11'd1024;
   localparam logic [CFG_R_BITS-1:0] RESET_RADIUS = 3'd3;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS = 2'd2;

   // Input item kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Solidity threshold and the value of a painted channel.
   localparam logic [CHAN_BITS-1:0] ALPHA_VISIBLE = 8'd12;
   localparam logic [CHAN_BITS-1:0] FULL_CHAN     = 8'd255;

   // Depth of the result queue at the output.
   localparam int OUTQ_DEPTH = 4;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [CFG_W_BITS-1:0] width;
      logic [CFG_H_BITS-1:0] height;
      logic [CFG_R_BITS-1:0] radius;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] alpha;
      logic                 outlined;
      logic                 frame_last;
   } res_type;

   // True when the offset (adx, ady) lies inside the disk of radius rad + 1.
   function automatic logic disk_hit(input logic [3:0] adx, input logic [3:0] ady,
                                     input logic [3:0] rad);
      logic [7:0] dist_sq;
      logic [7:0] lim;
      dist_sq = 8'(adx) * 8'(adx) + 8'(ady) * 8'(ady);
      lim     = (8'(rad) + 8'd1) * (8'(rad) + 8'd1);
      return dist_sq <= lim;
   endfunction

endpackage

// ===== sv/adilo_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adilo_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds while no read is requested; a read of the entry being written
// returns the old contents.
// ----------------------------------------------------------------------------
module adilo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/adilo_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adilo_csr
// Configuration registers behind a simple APB-style port: frame width,
// frame height and outline radius.
// ----------------------------------------------------------------------------
module adilo_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adilo_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [adilo_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [adilo_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                 pready,
   output adilo_pkg::cfg_type                   cfg_o
);

   adilo_pkg::cfg_type cfg_ff;
   adilo_pkg::cfg_type cfg_in;
   logic               wr_go;

   assign pready = 1'b1;
   assign wr_go  = psel & penable & pwrite;

   // Register writes, decoded on the word index.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_go) begin
         unique case (paddr[3:2])
            adilo_pkg::REG_WIDTH:  cfg_in.width  = pwdata[adilo_pkg::CFG_W_BITS-1:0];
            adilo_pkg::REG_HEIGHT: cfg_in.height = pwdata[adilo_pkg::CFG_H_BITS-1:0];
            adilo_pkg::REG_RADIUS: cfg_in.radius = pwdata[adilo_pkg::CFG_R_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= adilo_pkg::RESET_WIDTH;
         cfg_ff.height <= adilo_pkg::RESET_HEIGHT;
         cfg_ff.radius <= adilo_pkg::RESET_RADIUS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (paddr[3:2])
         adilo_pkg::REG_WIDTH:  prdata = adilo_pkg::CSR_DATA_BITS'(cfg_ff.width);
         adilo_pkg::REG_HEIGHT: prdata = adilo_pkg::CSR_DATA_BITS'(cfg_ff.height);
         adilo_pkg::REG_RADIUS: prdata = adilo_pkg::CSR_DATA_BITS'(cfg_ff.radius);
         default: prdata = '0;
      endcase
   end

   assign cfg_o = cfg_ff;

endmodule

// ===== sv/adilo_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adilo_window
// Solidity line buffer with read-modify-write, the square window of solid
// bits, and the disk test that decides whether a pixel is painted white.
// Stage one takes the line buffer column and shifts the window; stage two
// evaluates the disk around the pixel that leaves.
// ----------------------------------------------------------------------------
module adilo_window #(
   parameter int MAX_WIDTH  = adilo_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = adilo_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = adilo_pkg::DEF_MAX_RADIUS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step_i,
   input  logic                                   emit_i,
   input  logic                                   solid_i,
   input  logic [$clog2(MAX_WIDTH)-1:0]           lb_addr_i,
   input  logic                                   pix_fwd_i,
   input  logic [adilo_pkg::PIXEL_BITS-1:0]       pix_in_i,
   input  logic [adilo_pkg::PIXEL_BITS-1:0]       pix_rd_i,
   input  logic [$clog2(MAX_WIDTH)-1:0]           qx_i,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        qy_i,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         fw_i,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        fh_i,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]        fr_i,
   output logic [1:0]                             busy_o,
   output logic                                   push_o,
   output adilo_pkg::res_type                     push_data_o
);

   localparam int COLW = $clog2(MAX_WIDTH);
   localparam int FWW  = $clog2(MAX_WIDTH + 1);
   localparam int ROWW = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int LBW  = 2 * MAX_RADIUS;
   localparam int WIN  = 2 * MAX_RADIUS + 1;
   localparam int PB   = adilo_pkg::PIXEL_BITS;
   localparam int CB   = adilo_pkg::CHAN_BITS;

   // Stage one registers.
   logic            s1_valid_ff;
   logic            s1_emit_ff;
   logic            s1_solid_ff;
   logic [COLW-1:0] s1_addr_ff;
   logic            s1_fwdlb_ff;
   logic            s1_fwdpix_ff;
   logic [PB-1:0]   s1_pix_ff;
   logic [COLW-1:0] s1_qx_ff;
   logic [ROWW-1:0] s1_qy_ff;
   logic [FWW-1:0]  s1_fw_ff;
   logic [ROWW-1:0] s1_fh_ff;
   logic [RW-1:0]   s1_fr_ff;

   // Stage two registers.
   logic            s2_emit_ff;
   logic [PB-1:0]   s2_pix_ff;
   logic [COLW-1:0] s2_qx_ff;
   logic [ROWW-1:0] s2_qy_ff;
   logic [FWW-1:0]  s2_fw_ff;
   logic [ROWW-1:0] s2_fh_ff;
   logic [RW-1:0]   s2_fr_ff;

   logic [LBW-1:0]  lb_rd;
   logic [LBW-1:0]  lb_wdata_ff;
   logic [LBW-1:0]  lb_col;
   logic [WIN-1:0]  new_col;
   logic [WIN-1:0]  win_ff [WIN];
   logic            fwd_lb;
   logic [WIN-1:0]  col_ok;
   logic [WIN-1:0]  row_ok;
   logic            near;

   // Line buffer: one word per column, holding the solid bits of the rows above.
   adilo_ram #(
      .WIDTH (LBW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (new_col[LBW-1:0]),
      .rd_en   (step_i),
      .rd_addr (lb_addr_i),
      .rd_data (lb_rd)
   );

   // A column read while the same column is written back is taken from the write.
   assign fwd_lb = step_i & s1_valid_ff & (lb_addr_i == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
         s2_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= step_i;
         s1_emit_ff  <= emit_i;
         s2_emit_ff  <= s1_emit_ff;
      end
   end

   // Payload of stage one.
   always_ff @(posedge clock) begin
      if (step_i) begin
         s1_solid_ff  <= solid_i;
         s1_addr_ff   <= lb_addr_i;
         s1_fwdlb_ff  <= fwd_lb;
         s1_fwdpix_ff <= pix_fwd_i;
         s1_pix_ff    <= pix_in_i;
         s1_qx_ff     <= qx_i;
         s1_qy_ff     <= qy_i;
         s1_fw_ff     <= fw_i;
         s1_fh_ff     <= fh_i;
         s1_fr_ff     <= fr_i;
      end
   end

   // New column: newest row in bit zero, older rows above it.
   assign lb_col  = s1_fwdlb_ff ? lb_wdata_ff : lb_rd;
   assign new_col = {lb_col, s1_solid_ff};

   // Window shift, newest column in entry zero.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         lb_wdata_ff <= new_col[LBW-1:0];
         win_ff[0]   <= new_col;
         for (int c = 1; c < WIN; c++) begin
            win_ff[c] <= win_ff[c-1];
         end
      end
   end

   // Payload of stage two.
   always_ff @(posedge clock) begin
      if (s1_emit_ff) begin
         s2_pix_ff <= s1_fwdpix_ff ? s1_pix_ff : pix_rd_i;
         s2_qx_ff  <= s1_qx_ff;
         s2_qy_ff  <= s1_qy_ff;
         s2_fw_ff  <= s1_fw_ff;
         s2_fh_ff  <= s1_fh_ff;
         s2_fr_ff  <= s1_fr_ff;
      end
   end

   // Columns and rows of the window that fall inside the image.
   always_comb begin
      int x;
      int y;
      for (int c = 0; c < WIN; c++) begin
         x = int'(s2_qx_ff) + int'(s2_fr_ff) - c;
         y = int'(s2_qy_ff) + int'(s2_fr_ff) - c;
         col_ok[c] = (x >= 0) && (x < int'(s2_fw_ff));
         row_ok[c] = (y >= 0) && (y < int'(s2_fh_ff));
      end
   end

   // Disk test: any solid neighbour inside the disk, other than the centre, for a non-solid pixel.
   always_comb begin
      int dx;
      int dy;
      int r;
      logic hit;
      r    = int'(s2_fr_ff);
      near = 1'b0;
      for (int c = 0; c < WIN; c++) begin
         for (int k = 0; k < WIN; k++) begin
            dx  = (r >= c) ? (r - c) : (c - r);
            dy  = (r >= k) ? (r - k) : (k - r);
            hit = (c <= 2 * r) && (k <= 2 * r) && !((c == r) && (k == r)) &&
                  adilo_pkg::disk_hit(4'(dx), 4'(dy), 4'(r));
            if (hit && col_ok[c] && row_ok[k] && win_ff[c][k]) begin
               near = 1'b1;
            end
         end
      end
      if (s2_pix_ff[PB-1 -: CB] > adilo_pkg::ALPHA_VISIBLE) begin
         near = 1'b0;
      end
   end

   // Result item.
   always_comb begin
      if (near) begin
         push_data_o.red   = adilo_pkg::FULL_CHAN;
         push_data_o.green = adilo_pkg::FULL_CHAN;
         push_data_o.blue  = adilo_pkg::FULL_CHAN;
         push_data_o.alpha = adilo_pkg::FULL_CHAN;
      end else begin
         push_data_o.red   = s2_pix_ff[CB-1:0];
         push_data_o.green = s2_pix_ff[2*CB-1:CB];
         push_data_o.blue  = s2_pix_ff[3*CB-1:2*CB];
         push_data_o.alpha = s2_pix_ff[4*CB-1:3*CB];
      end
      push_data_o.outlined   = near;
      push_data_o.frame_last = (FWW'(s2_qx_ff) + FWW'(1) == s2_fw_ff) &&
                               (s2_qy_ff + ROWW'(1) == s2_fh_ff);
   end

   assign push_o = s2_emit_ff;
   assign busy_o = 2'(s1_emit_ff) + 2'(s2_emit_ff);

   // A forwarded column only ever follows a write to the same column.
   a_fwd_follows_write: assert property (@(posedge clock) disable iff (reset)
      fwd_lb |-> s1_valid_ff)
      else $error("line buffer forward without a write in flight");

   // An emitting item is always a window step.
   a_emit_is_step: assert property (@(posedge clock) disable iff (reset)
      emit_i |-> step_i)
      else $error("result issued without a window step");

   // Stage two only holds an item that passed stage one.
   a_s2_from_s1: assert property (@(posedge clock) disable iff (reset)
      s2_emit_ff |-> $past(s1_emit_ff))
      else $error("stage two result without stage one");

endmodule

// ===== sv/adilo_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adilo_outq
// Small result queue in front of the output channel. Entries are reserved
// before an item is taken in, so a push always finds room.
// ----------------------------------------------------------------------------
module adilo_outq #(
   parameter int DEPTH = adilo_pkg::OUTQ_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_i,
   input  adilo_pkg::res_type            push_data_i,
   output logic                          pop_valid_o,
   input  logic                          pop_ready_i,
   output adilo_pkg::res_type            pop_data_o,
   output logic [$clog2(DEPTH+1)-1:0]    count_o
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   adilo_pkg::res_type mem_ff [DEPTH];
   logic [PW-1:0] head_ff;
   logic [PW-1:0] head_in;
   logic [PW-1:0] tail_ff;
   logic [PW-1:0] tail_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          pop;

   assign pop = pop_valid_o & pop_ready_i;

   // Pointer and fill count update.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_i) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      if (push_i && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push_i) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[tail_ff] <= push_data_i;
      end
   end

   assign pop_valid_o = (count_ff != '0);
   assign pop_data_o  = mem_ff[head_ff];
   assign count_o     = count_ff;

   // The queue never overflows: room is reserved upstream.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> (count_ff < CW'(DEPTH)) || pop)
      else $error("result queue overflow");

   // The fill count stays within the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue count out of range");

   // A waiting result is not lost while the consumer stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (pop_valid_o && !pop_ready_i && !push_i) |=> (count_ff == $past(count_ff)))
      else $error("result queue changed during a stall");

endmodule

// ===== sv/alpha_disk_dilation_outline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_disk_dilation_outline
// Streaming outline of an RGBA image: non-solid pixels with a solid pixel
// inside a disk of the configured radius are painted opaque white.
//
//   channel  ports                                 direction  transfer when
//   req      req_kind, req_{red,green,blue,alpha}_in   in      req_valid & req_ready
//   rsp      rsp_{red,green,blue,alpha}_out,           out     rsp_valid & rsp_ready
//            rsp_outlined, rsp_frame_last
//   csr      psel, penable, pwrite, paddr, pwdata,     in/out  psel & penable & pwrite
//            prdata, pready
//
// One item per cycle is taken while req_ready is high; a result is released
// by a transfer and passes the line buffer read, window shift and disk test.
// A pixel leaves radius*width+radius transfers after it arrives; flush
// transfers drain the tail at one pixel each. For frames smaller than that
// delay the window is advanced internally after the last pixel, with
// req_ready low, until the output trails by the full delay.
// Reset needs no clearing pass. A stall on rsp holds up req only once the
// four-entry result queue is committed.
// ----------------------------------------------------------------------------
module alpha_disk_dilation_outline #(
   parameter int MAX_WIDTH  = adilo_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = adilo_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = adilo_pkg::DEF_MAX_RADIUS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [adilo_pkg::CHAN_BITS-1:0]      req_red_in,
   input  logic [adilo_pkg::CHAN_BITS-1:0]      req_green_in,
   input  logic [adilo_pkg::CHAN_BITS-1:0]      req_blue_in,
   input  logic [adilo_pkg::CHAN_BITS-1:0]      req_alpha_in,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [adilo_pkg::CHAN_BITS-1:0]      rsp_red_out,
   output logic [adilo_pkg::CHAN_BITS-1:0]      rsp_green_out,
   output logic [adilo_pkg::CHAN_BITS-1:0]      rsp_blue_out,
   output logic [adilo_pkg::CHAN_BITS-1:0]      rsp_alpha_out,
   output logic                                 rsp_outlined,
   output logic                                 rsp_frame_last,
   // Configuration port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [adilo_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [adilo_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [adilo_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                 pready
);

   localparam int COLW      = $clog2(MAX_WIDTH);
   localparam int FWW       = $clog2(MAX_WIDTH + 1);
   localparam int ROWW      = $clog2(MAX_HEIGHT + 1);
   localparam int RW        = $clog2(MAX_RADIUS + 1);
   localparam int DELAY_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int LAGW      = $clog2(DELAY_MAX + 1);
   localparam int PIX_DEPTH = DELAY_MAX + 1;
   localparam int PTRW      = $clog2(PIX_DEPTH);
   localparam int QCW       = $clog2(adilo_pkg::OUTQ_DEPTH + 1);
   localparam int PB        = adilo_pkg::PIXEL_BITS;

   adilo_pkg::cfg_type cfg;
   adilo_pkg::res_type res_push;
   adilo_pkg::res_type res_head;
   logic               res_push_valid;

   // Position and frame state.
   logic [COLW-1:0] in_col_ff,  in_col_in;
   logic [ROWW-1:0] in_row_ff,  in_row_in;
   logic [COLW-1:0] out_col_ff, out_col_in;
   logic [ROWW-1:0] out_row_ff, out_row_in;
   logic [COLW-1:0] vcol_ff,    vcol_in;
   logic [LAGW-1:0] lag_ff,     lag_in;
   logic [PTRW-1:0] wr_ptr_ff,  wr_ptr_in;
   logic [PTRW-1:0] rd_ptr_ff,  rd_ptr_in;
   logic [FWW-1:0]  fw_ff,      fw_in;
   logic [ROWW-1:0] fh_ff,      fh_in;
   logic [RW-1:0]   fr_ff,      fr_in;
   logic [LAGW-1:0] delay_ff,   delay_in;

   // Values for the current transfer, after a possible frame start.
   logic [FWW-1:0]  eff_w, w_e;
   logic [ROWW-1:0] eff_h, h_e;
   logic [RW-1:0]   eff_r, r_e;
   logic [LAGW-1:0] eff_delay, delay_e;
   logic [COLW-1:0] in_col_b, out_col_b, vcol_b;
   logic [ROWW-1:0] in_row_b, out_row_b;
   logic [LAGW-1:0] lag_b;
   logic [PTRW-1:0] wr_ptr_b, rd_ptr_b;

   logic in_done, pixel_go, flush_go, pad_go, start, step, emit, solid, pix_fwd;
   logic credit_ok;
   logic [1:0]     busy;
   logic [QCW-1:0] q_count;
   logic [QCW:0]   pending;
   logic [PB-1:0]  pix_in;
   logic [PB-1:0]  pix_rd;

   adilo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_o   (cfg)
   );

   // Saturated register values, used when a frame starts.
   always_comb begin
      if (cfg.width == '0) begin
         eff_w = FWW'(1);
      end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
         eff_w = FWW'(MAX_WIDTH);
      end else begin
         eff_w = FWW'(cfg.width);
      end
      if (cfg.height == '0) begin
         eff_h = ROWW'(1);
      end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
         eff_h = ROWW'(MAX_HEIGHT);
      end else begin
         eff_h = ROWW'(cfg.height);
      end
      if (32'(cfg.radius) > 32'(MAX_RADIUS)) begin
         eff_r = RW'(MAX_RADIUS);
      end else begin
         eff_r = RW'(cfg.radius);
      end
      eff_delay = LAGW'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
   end

   // Transfer decode. Once the input of a frame is complete, the window is
   // advanced without emitting until the output trails by the full delay.
   assign in_done   = (in_row_ff >= fh_ff);
   assign pad_go    = in_done && (out_row_ff < fh_ff) && (lag_ff != delay_ff);
   assign pending   = (QCW + 1)'(q_count) + (QCW + 1)'(busy);
   assign credit_ok = (pending < (QCW + 1)'(adilo_pkg::OUTQ_DEPTH));
   assign req_ready = credit_ok && !pad_go;
   assign pixel_go  = req_valid && req_ready && (req_kind == adilo_pkg::KIND_PIXEL);
   assign flush_go  = req_valid && req_ready && (req_kind == adilo_pkg::KIND_FLUSH) &&
                      in_done && (out_row_ff < fh_ff);
   assign start     = pixel_go && (in_done || ((in_row_ff == '0) && (in_col_ff == '0)));

   assign w_e       = start ? eff_w : fw_ff;
   assign h_e       = start ? eff_h : fh_ff;
   assign r_e       = start ? eff_r : fr_ff;
   assign delay_e   = start ? eff_delay : delay_ff;
   assign in_col_b  = start ? '0 : in_col_ff;
   assign in_row_b  = start ? '0 : in_row_ff;
   assign out_col_b = start ? '0 : out_col_ff;
   assign out_row_b = start ? '0 : out_row_ff;
   assign vcol_b    = start ? '0 : vcol_ff;
   assign lag_b     = start ? '0 : lag_ff;
   assign wr_ptr_b  = start ? '0 : wr_ptr_ff;
   assign rd_ptr_b  = start ? '0 : rd_ptr_ff;

   assign step    = pixel_go || flush_go || pad_go;
   assign emit    = (pixel_go && (lag_b == delay_e)) || flush_go;
   assign solid   = pixel_go && (req_alpha_in > adilo_pkg::ALPHA_VISIBLE);
   assign pix_in  = {req_alpha_in, req_blue_in, req_green_in, req_red_in};
   assign pix_fwd = pixel_go && emit && (rd_ptr_b == wr_ptr_b);

   // Next state of the counters.
   always_comb begin
      in_col_in  = in_col_b;
      in_row_in  = in_row_b;
      out_col_in = out_col_b;
      out_row_in = out_row_b;
      vcol_in    = vcol_b;
      lag_in     = lag_b;
      wr_ptr_in  = wr_ptr_b;
      rd_ptr_in  = rd_ptr_b;
      fw_in      = w_e;
      fh_in      = h_e;
      fr_in      = r_e;
      delay_in   = delay_e;
      if (!step) begin
         in_col_in  = in_col_ff;
         in_row_in  = in_row_ff;
         out_col_in = out_col_ff;
         out_row_in = out_row_ff;
         vcol_in    = vcol_ff;
         lag_in     = lag_ff;
         wr_ptr_in  = wr_ptr_ff;
         rd_ptr_in  = rd_ptr_ff;
      end else begin
         if (pixel_go) begin
            if (FWW'(in_col_b) + FWW'(1) == w_e) begin
               in_col_in = '0;
               in_row_in = in_row_b + ROWW'(1);
            end else begin
               in_col_in = in_col_b + COLW'(1);
            end
            wr_ptr_in = (wr_ptr_b == PTRW'(PIX_DEPTH - 1)) ? '0 : wr_ptr_b + PTRW'(1);
         end
         vcol_in = (FWW'(vcol_b) + FWW'(1) == w_e) ? '0 : vcol_b + COLW'(1);
         if (emit) begin
            if (FWW'(out_col_b) + FWW'(1) == w_e) begin
               out_col_in = '0;
               out_row_in = out_row_b + ROWW'(1);
            end else begin
               out_col_in = out_col_b + COLW'(1);
            end
            rd_ptr_in = (rd_ptr_b == PTRW'(PIX_DEPTH - 1)) ? '0 : rd_ptr_b + PTRW'(1);
         end else begin
            lag_in = lag_b + LAGW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         vcol_ff    <= '0;
         lag_ff     <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fw_ff      <= FWW'(1);
         fh_ff      <= ROWW'(1);
         fr_ff      <= '0;
         delay_ff   <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         vcol_ff    <= vcol_in;
         lag_ff     <= lag_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         fr_ff      <= fr_in;
         delay_ff   <= delay_in;
      end
   end

   // Pixel delay line: written on arrival, read when the pixel leaves.
   adilo_ram #(
      .WIDTH (PB),
      .DEPTH (PIX_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pixel_go),
      .wr_addr (wr_ptr_b),
      .wr_data (pix_in),
      .rd_en   (emit),
      .rd_addr (rd_ptr_b),
      .rd_data (pix_rd)
   );

   adilo_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .step_i      (step),
      .emit_i      (emit),
      .solid_i     (solid),
      .lb_addr_i   (vcol_b),
      .pix_fwd_i   (pix_fwd),
      .pix_in_i    (pix_in),
      .pix_rd_i    (pix_rd),
      .qx_i        (out_col_b),
      .qy_i        (out_row_b),
      .fw_i        (w_e),
      .fh_i        (h_e),
      .fr_i        (r_e),
      .busy_o      (busy),
      .push_o      (res_push_valid),
      .push_data_o (res_push)
   );

   adilo_outq #(
      .DEPTH (adilo_pkg::OUTQ_DEPTH)
   ) u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_i      (res_push_valid),
      .push_data_i (res_push),
      .pop_valid_o (rsp_valid),
      .pop_ready_i (rsp_ready),
      .pop_data_o  (res_head),
      .count_o     (q_count)
   );

   assign rsp_red_out    = res_head.red;
   assign rsp_green_out  = res_head.green;
   assign rsp_blue_out   = res_head.blue;
   assign rsp_alpha_out  = res_head.alpha;
   assign rsp_outlined   = res_head.outlined;
   assign rsp_frame_last = res_head.frame_last;

   // The output never trails the input by more than the frame delay.
   a_lag_bound: assert property (@(posedge clock) disable iff (reset)
      lag_ff <= delay_ff)
      else $error("output lag beyond the frame delay");

   // A pixel read from the entry written in the same cycle happens only at radius zero.
   a_same_entry: assert property (@(posedge clock) disable iff (reset)
      pix_fwd |-> (delay_e == '0))
      else $error("pixel delay line overlap at non-zero delay");

   // Results in flight plus queued never exceed the queue depth.
   a_credit: assert property (@(posedge clock) disable iff (reset)
      pending <= (QCW + 1)'(adilo_pkg::OUTQ_DEPTH))
      else $error("result credit overrun");

endmodule
